### rtl/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// Types and codes shared by the bounded array list and its testbench.
// ----------------------------------------------------------------------------
package bal_pkg;

    typedef logic [2:0] kind_t;
    typedef logic [2:0] status_t;

    localparam kind_t KIND_PUSH   = 3'd0;
    localparam kind_t KIND_POP    = 3'd1;
    localparam kind_t KIND_INSERT = 3'd2;
    localparam kind_t KIND_ERASE  = 3'd3;
    localparam kind_t KIND_READ   = 3'd4;
    localparam kind_t KIND_WRITE  = 3'd5;
    localparam kind_t KIND_RESIZE = 3'd6;
    localparam kind_t KIND_CLEAR  = 3'd7;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BAD_INDEX = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_BAD_SIZE  = 3'd4;

    localparam int WORD_W  = 64;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 7;

    typedef struct packed {
        kind_t               kind;
        logic [INDEX_W-1:0]  index;
        logic [INDEX_W-1:0]  new_size;
        logic [WORD_W-1:0]   value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_value;
        status_t             status;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

endpackage

### rtl/bal_ram.sv
// ----------------------------------------------------------------------------
// bal_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bal_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/bounded_array_list.sv
// Sequence: each operation is taken in S_IDLE, carried out in S_EXEC and answered
// from S_FIN, which waits while the result word is stalled. Read passes through
// S_READ, insert through S_SHIFT and S_PUT, erase through S_SHIFT (but for the last
// word), moving each word through the RAM; the rest and any error go on to S_FIN.
// One operation is handled at a time. Reset: count goes to zero and a clearing pass
// writes zero to all CAPACITY slots, one per cycle; req_stall stays high until it ends.
// ----------------------------------------------------------------------------
// bounded_array_list
// Fixed-capacity ordered list of 64-bit words with a live count, stored in a
// RAM and shifted one word per cycle by a small sequencer.
// ----------------------------------------------------------------------------
module bounded_array_list #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bal_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bal_pkg::rsp_t rsp
);

    import bal_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [INDEX_W-1:0]  size_reg, size_next;
    logic [WORD_W-1:0]   value_reg, value_next;
    logic [CW-1:0]       count_reg, count_next;
    status_t             status_reg, status_next;
    logic [WORD_W-1:0]   rdval_reg, rdval_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       end_reg, end_next;
    logic [AW-1:0]       wa_reg, wa_next;
    logic                pend_reg, pend_next;
    logic                last_reg, last_next;
    logic                up_reg, up_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [WORD_W-1:0]   mem_rdata;

    logic [CMPW-1:0]     idx_ext;
    logic [CMPW-1:0]     cnt_ext;
    logic [CMPW-1:0]     size_ext;
    logic [AW-1:0]       idx_a;
    logic [AW-1:0]       cnt_a;
    logic [AW-1:0]       cnt_m1_a;
    logic                idx_bad;
    logic                is_full;
    logic                rsp_free;

    bal_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign idx_ext  = CMPW'(index_reg);
    assign cnt_ext  = CMPW'(count_reg);
    assign size_ext = CMPW'(size_reg);
    assign idx_a    = idx_ext[AW-1:0];
    assign cnt_a    = AW'(count_reg);
    assign cnt_m1_a = AW'(count_reg - CW'(1));
    assign idx_bad  = idx_ext >= cnt_ext;
    assign is_full  = count_reg >= CW'(CAPACITY);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        index_next     = index_reg;
        size_next      = size_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        rdval_next     = rdval_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        wa_next        = wa_reg;
        pend_next      = pend_reg;
        last_next      = last_reg;
        up_next        = up_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = '0;
        mem_raddr      = ptr_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                if (ptr_reg == AW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req.kind;
                    index_next = req.index;
                    size_next  = req.new_size;
                    value_next = req.value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                status_next = ST_OK;
                rdval_next  = '0;
                state_next  = S_FIN;
                unique case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = cnt_a;
                            mem_wdata  = value_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    KIND_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = cnt_m1_a;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    KIND_INSERT:
                    begin
                        if (idx_bad)
                        begin
                            status_next = ST_BAD_INDEX;
                        end
                        else if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // move words from count-1 down to index up by one
                            ptr_next   = cnt_m1_a;
                            end_next   = idx_a;
                            up_next    = 1'b1;
                            pend_next  = 1'b0;
                            last_next  = 1'b0;
                            count_next = count_reg + CW'(1);
                            state_next = S_SHIFT;
                        end
                    end
                    KIND_ERASE:
                    begin
                        if (idx_bad)
                        begin
                            status_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            if (idx_ext == cnt_ext - CMPW'(1))
                            begin
                                // erasing the last word leaves zero behind
                                mem_we    = 1'b1;
                                mem_waddr = idx_a;
                            end
                            else
                            begin
                                // old last word stays in its slot
                                ptr_next   = idx_a + AW'(1);
                                end_next   = cnt_m1_a;
                                up_next    = 1'b0;
                                pend_next  = 1'b0;
                                last_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    KIND_READ:
                    begin
                        if (idx_bad)
                        begin
                            status_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            mem_raddr  = idx_a;
                            state_next = S_READ;
                        end
                    end
                    KIND_WRITE:
                    begin
                        if (idx_bad)
                        begin
                            status_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_a;
                            mem_wdata = value_reg;
                        end
                    end
                    KIND_RESIZE:
                    begin
                        if (size_ext > CMPW'(CAPACITY))
                        begin
                            status_next = ST_BAD_SIZE;
                        end
                        else
                        begin
                            count_next = CW'(size_ext);
                        end
                    end
                    KIND_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_READ:
            begin
                rdval_next = mem_rdata;
                state_next = S_FIN;
            end

            S_SHIFT:
            begin
                // read one slot per cycle and write it in the following cycle one place over
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wa_reg;
                    mem_wdata = mem_rdata;
                end
                if (!last_reg)
                begin
                    mem_raddr = ptr_reg;
                    wa_next   = up_reg ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
                    pend_next = 1'b1;
                    if (ptr_reg == end_reg)
                    begin
                        last_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = up_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    last_next  = 1'b0;
                    state_next = up_reg ? S_PUT : S_FIN;
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_a;
                mem_wdata  = value_reg;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.read_value = rdval_reg;
                    rsp_next.status     = status_reg;
                    rsp_next.count      = COUNT_W'(count_reg);
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            last_reg      <= 1'b0;
            up_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            last_reg      <= last_next;
            up_reg        <= up_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        index_reg  <= index_next;
        size_reg   <= size_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
        end_reg    <= end_next;
        wa_reg     <= wa_next;
        rsp_reg    <= rsp_next;
    end

endmodule

### dv/bounded_array_list_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_array_list_test
// Sends list operations through the request channel and checks every result
// word against a pinned answer or a behavioral copy of the list, under varied idling and stalls.
// ----------------------------------------------------------------------------
module bounded_array_list_test;
    import bal_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int PHASE_ITEMS  = 340;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [WORD_W-1:0] ONES = '1;
    localparam logic [WORD_W-1:0] ZERO = '0;

    typedef struct packed {
        req_t op;
        bit   pinned;
        rsp_t result;
    } dir_row_t;

    typedef struct packed {
        bit   pinned;
        rsp_t result;
    } pinned_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    // behavioral copy of the list
    logic [WORD_W-1:0] list_mem [CAPACITY];
    int                list_len = 0;
    bit                growing  = 1'b1;

    rsp_t    pending_results [$];
    pinned_t pinned_results [$];
    int      mismatches   = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    bit      hold_off      = 1'b0;

    // known answers only where they follow directly from the state
    dir_row_t directed_rows [25] = '{
        '{'{KIND_POP,    8'd0,   8'd0,   ZERO}, 1'b1, '{ZERO, ST_EMPTY,     7'd0}},
        '{'{KIND_READ,   8'd0,   8'd0,   ZERO}, 1'b1, '{ZERO, ST_BAD_INDEX, 7'd0}},
        '{'{KIND_INSERT, 8'd0,   8'd0,   ONES}, 1'b1, '{ZERO, ST_BAD_INDEX, 7'd0}},
        '{'{KIND_ERASE,  8'd255, 8'd0,   ZERO}, 1'b1, '{ZERO, ST_BAD_INDEX, 7'd0}},
        '{'{KIND_WRITE,  8'd0,   8'd0,   ONES}, 1'b1, '{ZERO, ST_BAD_INDEX, 7'd0}},
        '{'{KIND_RESIZE, 8'd0,   8'd65,  ZERO}, 1'b1, '{ZERO, ST_BAD_SIZE,  7'd0}},
        '{'{KIND_RESIZE, 8'd255, 8'd255, ONES}, 1'b1, '{ZERO, ST_BAD_SIZE,  7'd0}},
        '{'{KIND_PUSH,   8'd0,   8'd0,   ONES}, 1'b1, '{ZERO, ST_OK,        7'd1}},
        '{'{KIND_PUSH,   8'd0,   8'd0,   ZERO}, 1'b1, '{ZERO, ST_OK,        7'd2}},
        '{'{KIND_INSERT, 8'd0, 8'd0, 64'h8000_0000_0000_0001}, 1'b0, '0},
        '{'{KIND_READ,   8'd0,   8'd0,   ZERO}, 1'b0, '0},
        '{'{KIND_READ,   8'd1,   8'd0,   ZERO}, 1'b0, '0},
        '{'{KIND_ERASE,  8'd2,   8'd0,   ZERO}, 1'b0, '0},
        '{'{KIND_WRITE,  8'd1, 8'd0, 64'h0123_4567_89AB_CDEF}, 1'b0, '0},
        '{'{KIND_POP,    8'd0,   8'd0,   ZERO}, 1'b0, '0},
        '{'{KIND_RESIZE, 8'd0,   8'd64,  ZERO}, 1'b1, '{ZERO, ST_OK,        7'd64}},
        '{'{KIND_PUSH,   8'd0,   8'd0,   ONES}, 1'b1, '{ZERO, ST_FULL,      7'd64}},
        '{'{KIND_INSERT, 8'd0,   8'd0,   ONES}, 1'b1, '{ZERO, ST_FULL,      7'd64}},
        '{'{KIND_INSERT, 8'd255, 8'd0,   ONES}, 1'b1, '{ZERO, ST_BAD_INDEX, 7'd64}},
        '{'{KIND_READ,   8'd63,  8'd0,   ZERO}, 1'b0, '0},
        '{'{KIND_ERASE,  8'd0,   8'd0,   ZERO}, 1'b0, '0},
        '{'{KIND_READ,   8'd63,  8'd0,   ZERO}, 1'b1, '{ZERO, ST_BAD_INDEX, 7'd63}},
        '{'{KIND_RESIZE, 8'd0,   8'd0,   ZERO}, 1'b1, '{ZERO, ST_OK,        7'd0}},
        '{'{KIND_RESIZE, 8'd0,   8'd64,  ZERO}, 1'b1, '{ZERO, ST_OK,        7'd64}},
        '{'{KIND_CLEAR,  8'd255, 8'd255, ONES}, 1'b1, '{ZERO, ST_OK,        7'd0}}
    };

    bounded_array_list #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
            list_mem[i] = '0;
    end

    // applies one operation to the list copy and returns its result word
    function automatic rsp_t list_op_result(req_t op);
        rsp_t r;
        int   idx;
        int   i;
        r = '0;
        r.status = ST_OK;
        idx = int'(op.index);
        case (op.kind)
            KIND_PUSH:
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = op.value;
                    list_len++;
                end
            KIND_POP:
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    list_len--;
                    list_mem[list_len] = '0;
                end
            KIND_INSERT:
                if (idx >= list_len)
                    r.status = ST_BAD_INDEX;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > idx; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[idx] = op.value;
                    list_len++;
                end
            KIND_ERASE:
                if (idx >= list_len)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    // the old last word stays behind in its slot
                    list_mem[idx] = '0;
                    for (i = idx; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            KIND_READ:
                if (idx >= list_len)
                    r.status = ST_BAD_INDEX;
                else
                    r.read_value = list_mem[idx];
            KIND_WRITE:
                if (idx >= list_len)
                    r.status = ST_BAD_INDEX;
                else
                    list_mem[idx] = op.value;
            KIND_RESIZE:
                if (int'(op.new_size) > CAPACITY)
                    r.status = ST_BAD_SIZE;
                else
                    list_len = int'(op.new_size);
            default:
                list_len = 0;
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    // mostly in-range operations, drifting the length between empty and full
    function automatic req_t random_op();
        req_t op;
        int   p;
        int   r;
        if (list_len >= CAPACITY)
            growing = 1'b0;
        else if (list_len == 0)
            growing = 1'b1;
        else if ($urandom_range(49) == 0)
            growing = !growing;

        p = $urandom_range(99);
        if (growing)
        begin
            if (p < 30)      op.kind = KIND_PUSH;
            else if (p < 50) op.kind = KIND_INSERT;
            else if (p < 56) op.kind = KIND_POP;
            else if (p < 62) op.kind = KIND_ERASE;
            else if (p < 76) op.kind = KIND_READ;
            else if (p < 90) op.kind = KIND_WRITE;
            else if (p < 99) op.kind = KIND_RESIZE;
            else             op.kind = KIND_CLEAR;
        end
        else
        begin
            if (p < 6)       op.kind = KIND_PUSH;
            else if (p < 12) op.kind = KIND_INSERT;
            else if (p < 34) op.kind = KIND_POP;
            else if (p < 58) op.kind = KIND_ERASE;
            else if (p < 74) op.kind = KIND_READ;
            else if (p < 88) op.kind = KIND_WRITE;
            else if (p < 98) op.kind = KIND_RESIZE;
            else             op.kind = KIND_CLEAR;
        end

        r = $urandom_range(99);
        if (list_len > 0 && r < 80)
            op.index = 8'($urandom_range(list_len - 1));
        else if (r < 90)
            op.index = 8'(list_len);
        else
            op.index = 8'($urandom_range(255));

        r = $urandom_range(99);
        if (r < 75)
            op.new_size = 8'($urandom_range(CAPACITY));
        else if (r < 85)
            op.new_size = 8'(CAPACITY);
        else
            op.new_size = 8'($urandom_range(255));

        r = $urandom_range(7);
        if (r == 0)
            op.value = ZERO;
        else if (r == 1)
            op.value = ONES;
        else
            op.value = {$urandom, $urandom};
        return op;
    endfunction

    // holds the word until it is taken, with random idle cycles ahead of it
    task automatic offer_word(input req_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= op;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off && held < HOLD_CYCLES)
            begin
                rsp_stall <= 1'b1;
                held++;
            end
            else
                rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_t    want;
        pinned_t pin;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing pending: %h", rsp);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, rsp.read_value);
                        mismatches++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, rsp.count);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                pin  = pinned_results.pop_front();
                want = list_op_result(req);
                pending_results.insert(pending_results.size(),
                                       pin.pinned ? pin.result : want);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL bounded_array_list");
        $finish;
    end

    initial
    begin
        int send_pcts  [5];
        int stall_pcts [5];
        int k;
        int phase;
        send_pcts  = '{0, 47, 0, 31, 0};
        stall_pcts = '{0, 0, 47, 31, 0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 25; k++)
        begin
            pinned_results.insert(pinned_results.size(),
                                  '{directed_rows[k].pinned, directed_rows[k].result});
            offer_word(directed_rows[k].op);
        end

        // last phase: receiver holds off while the sender keeps offering
        for (phase = 0; phase < 5; phase++)
        begin
            send_idle_pct = send_pcts[phase];
            stall_pct     = stall_pcts[phase];
            if (phase == 4)
                hold_off = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                pinned_results.insert(pinned_results.size(), '{1'b0, '0});
                offer_word(random_op());
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS bounded_array_list");
        else
            $display("FAIL bounded_array_list");
        $finish;
    end

endmodule
